FILE: hw/rtl/tpss_pkg.sv
// Shared types and constants for the trapezoid profile setpoint step block.
`default_nettype none
package tpss_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_ACCEL_LIMIT   = 3'd0;
  localparam logic [2:0] REG_SPEED_LIMIT   = 3'd1;
  localparam logic [2:0] REG_DERATING      = 3'd2;
  localparam logic [2:0] REG_LOOP_RATE     = 3'd3;
  localparam logic [2:0] REG_RESP_DELAY    = 3'd4;

  localparam logic [15:0] DERATE_FULL = 16'd32768;
  localparam logic [52:0] AD_CAP      = 53'h10_0000_0000_0000;

  // The delay term is delay * 2^32 / 10^6 = delay * 4294 + delay * 15114 / 15625.
  // The last quotient uses a reciprocal of 15625 scaled by 2^48, exact below 2^34.
  localparam logic [12:0] DLY_INT   = 13'd4294;
  localparam logic [13:0] DLY_FRAC  = 14'd15114;
  localparam logic [34:0] DLY_RECIP = 35'd18014398510;

  // Width of the multiplicand that feeds the radicand product.
  localparam int XW = 53;

  // Depth of the queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef enum logic [1:0] {
    KIND_ACCEL  = 2'd0,
    KIND_CRUISE = 2'd1,
    KIND_DECEL  = 2'd2
  } kind_t;

  typedef struct packed {
    logic  err;
    logic  neg;
    kind_t kind;
  } ctl_t;

  // Values derived from the configuration registers.
  typedef struct packed {
    logic [31:0] vmax;
    logic [32:0] two_acc;
    logic [63:0] vsq;
    logic [52:0] ad;
    logic [1:0]  t_hi;
    logic [31:0] t_lo;
    logic        rate_zero;
  } coef_t;

endpackage
`default_nettype wire

FILE: hw/rtl/tpss_coef.sv
// Sequential unit that derives the profile coefficients from the configuration registers.
`default_nettype none
module tpss_coef (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [31:0]   accel_limit,
  input  wire logic [31:0]   speed_limit,
  input  wire logic [15:0]   derating,
  input  wire logic [15:0]   loop_rate_hz,
  input  wire logic [19:0]   response_delay_us,
  output tpss_pkg::coef_t    coef,
  output logic               busy
);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b00000001,
    ST_SCALE   = 8'b00000010,
    ST_SQUARE  = 8'b00000100,
    ST_LOAD_AD = 8'b00001000,
    ST_DIV_AD  = 8'b00010000,
    ST_DIV_PER = 8'b00100000,
    ST_DLY_MUL = 8'b01000000,
    ST_DLY_SUM = 8'b10000000
  } state_t;

  state_t      state;
  logic [31:0] acc;
  logic [31:0] vmax;
  logic [63:0] vsq;
  logic [52:0] ad;
  logic [32:0] tper;
  logic [33:0] tsum;

  logic [63:0] dnum;
  logic [32:0] dden;
  logic [32:0] drem;
  logic [63:0] dq;
  logic [6:0]  dcnt;

  logic [51:0] dly_plo;
  logic [50:0] dly_phi;

  logic [15:0] d_sat;
  logic [47:0] acc_prod;
  logic [47:0] vmax_prod;
  logic [32:0] two_acc;
  logic [33:0] r2;
  logic        ge;
  logic        rate_zero;
  logic [33:0] dly_x;
  logic [32:0] dly_int;
  logic [69:0] dly_prod;

  assign d_sat     = (derating > tpss_pkg::DERATE_FULL) ? tpss_pkg::DERATE_FULL : derating;
  assign acc_prod  = 48'(accel_limit) * 48'(d_sat);
  assign vmax_prod = 48'(speed_limit) * 48'(d_sat);
  assign two_acc   = {acc, 1'b0};
  assign rate_zero = (loop_rate_hz == 16'd0);

  assign dly_x    = 34'(response_delay_us) * 34'(tpss_pkg::DLY_FRAC);
  assign dly_int  = 33'(response_delay_us) * 33'(tpss_pkg::DLY_INT);
  assign dly_prod = {1'b0, dly_phi, 18'd0} + 70'(dly_plo);

  // One restoring division step per cycle.
  assign r2 = {drem, dnum[63]};
  assign ge = (r2 >= {1'b0, dden});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SCALE;
    end else if (start) begin
      state <= ST_SCALE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          state <= ST_IDLE;
        end
        ST_SCALE: begin
          acc   <= acc_prod[46:15];
          vmax  <= vmax_prod[46:15];
          state <= ST_SQUARE;
        end
        ST_SQUARE: begin
          vsq   <= 64'(vmax) * 64'(vmax);
          state <= ST_LOAD_AD;
        end
        ST_LOAD_AD: begin
          if (two_acc == 33'd0) begin
            ad <= tpss_pkg::AD_CAP;
            if (rate_zero) begin
              state <= ST_IDLE;
            end else begin
              dnum  <= 64'h1_0000_0000;
              dden  <= 33'(loop_rate_hz);
              drem  <= '0;
              dcnt  <= 7'd64;
              state <= ST_DIV_PER;
            end
          end else begin
            dnum  <= vsq;
            dden  <= two_acc;
            drem  <= '0;
            dcnt  <= 7'd64;
            state <= ST_DIV_AD;
          end
        end
        ST_DIV_AD, ST_DIV_PER: begin
          if (dcnt != 7'd0) begin
            drem <= ge ? 33'(r2 - {1'b0, dden}) : r2[32:0];
            dq   <= {dq[62:0], ge};
            dnum <= {dnum[62:0], 1'b0};
            dcnt <= dcnt - 7'd1;
          end else if (state == ST_DIV_AD) begin
            // Ceiling of the quotient, capped.
            if (dq >= 64'(tpss_pkg::AD_CAP)) begin
              ad <= tpss_pkg::AD_CAP;
            end else begin
              ad <= dq[52:0] + 53'(drem != 33'd0);
            end
            if (rate_zero) begin
              state <= ST_IDLE;
            end else begin
              dnum  <= 64'h1_0000_0000;
              dden  <= 33'(loop_rate_hz);
              drem  <= '0;
              dcnt  <= 7'd64;
              state <= ST_DIV_PER;
            end
          end else begin
            tper  <= dq[32:0];
            state <= ST_DLY_MUL;
          end
        end
        ST_DLY_MUL: begin
          dly_plo <= 52'(dly_x) * 52'(tpss_pkg::DLY_RECIP[17:0]);
          dly_phi <= 51'(dly_x) * 51'(tpss_pkg::DLY_RECIP[34:18]);
          state   <= ST_DLY_SUM;
        end
        ST_DLY_SUM: begin
          tsum  <= 34'(tper) + 34'(dly_int) + 34'(dly_prod[68:48]);
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    coef.vmax      = vmax;
    coef.two_acc   = two_acc;
    coef.vsq       = vsq;
    coef.ad        = ad;
    coef.t_hi      = tsum[33:32];
    coef.t_lo      = tsum[31:0];
    coef.rate_zero = rate_zero;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/tpss_front.sv
// Front end: accepts items, forms the distance and classifies the profile phase.
`default_nettype none
module tpss_front #(
  parameter int POS_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [POS_WIDTH-1:0]   in_prior,
  input  wire logic [POS_WIDTH-1:0]   in_goal,
  input  wire tpss_pkg::coef_t        coef,
  input  wire logic                   busy,
  input  wire logic                   q_full,
  output logic                        push,
  output tpss_pkg::ctl_t              push_ctl,
  output logic [POS_WIDTH-1:0]        push_prior,
  output logic [tpss_pkg::XW-1:0]     push_x
);

  localparam int DW = POS_WIDTH + 1;
  localparam int CW = (DW > 54) ? DW : 54;

  logic                 fen;
  logic                 f1_v;
  logic [POS_WIDTH-1:0] f1_prior;
  logic [POS_WIDTH-1:0] f1_goal;
  logic [DW-1:0]        f1_diff;
  logic                 f2_v;
  logic [POS_WIDTH-1:0] f2_prior;
  logic [POS_WIDTH-1:0] f2_goal;
  logic                 f2_neg;
  logic [DW-1:0]        f2_dist;

  logic [CW-1:0]        dist_ext;
  logic [CW-1:0]        ad_ext;
  logic [CW-1:0]        ad2_ext;
  logic [CW:0]          dist_less;
  logic                 is_accel;
  logic                 is_cruise;

  assign fen      = !q_full;
  assign in_ready = fen && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
    end else if (fen) begin
      f1_v <= in_valid && in_ready;
      f2_v <= f1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      f1_prior <= in_prior;
      f1_goal  <= in_goal;
      f1_diff  <= {in_goal[POS_WIDTH-1], in_goal} - {in_prior[POS_WIDTH-1], in_prior};
      f2_prior <= f1_prior;
      f2_goal  <= f1_goal;
      f2_neg   <= f1_diff[DW-1];
      f2_dist  <= f1_diff[DW-1] ? (~f1_diff + DW'(1)) : f1_diff;
    end
  end

  assign dist_ext  = CW'(f2_dist);
  assign ad_ext    = CW'(coef.ad);
  assign ad2_ext   = CW'({coef.ad, 1'b0});
  assign dist_less = {1'b0, dist_ext} - {1'b0, ad_ext};
  assign is_accel  = dist_less[CW];
  assign is_cruise = (dist_ext > ad2_ext);

  assign push = fen && f2_v;

  always_comb begin
    push_ctl.err = coef.rate_zero;
    push_ctl.neg = f2_neg;
    if (is_accel) begin
      push_ctl.kind = tpss_pkg::KIND_ACCEL;
      push_x        = tpss_pkg::XW'(dist_ext);
    end else if (is_cruise) begin
      push_ctl.kind = tpss_pkg::KIND_CRUISE;
      push_x        = tpss_pkg::XW'(dist_less[CW-1:0]);
    end else begin
      push_ctl.kind = tpss_pkg::KIND_DECEL;
      push_x        = tpss_pkg::XW'(dist_less[CW-1:0]);
    end
    // With no loop rate the goal passes straight through.
    push_prior = coef.rate_zero ? f2_goal : f2_prior;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/tpss_queue.sv
// Short queue of classified items between the front and back ends.
`default_nettype none
module tpss_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  valid,
  output logic                  full
);

  logic [WIDTH-1:0]       entries [0:tpss_pkg::QDEPTH-1];
  logic [tpss_pkg::QAW-1:0] wr_ptr;
  logic [tpss_pkg::QAW-1:0] rd_ptr;
  logic [tpss_pkg::QAW:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  assign dout  = entries[rd_ptr];
  assign valid = (count != '0);
  assign full  = (count == (tpss_pkg::QAW+1)'(tpss_pkg::QDEPTH));

endmodule
`default_nettype wire

FILE: hw/rtl/tpss_back.sv
// Back end: radicand product, pipelined square root, step scaling and saturation.
`default_nettype none
module tpss_back #(
  parameter int POS_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_valid,
  input  wire tpss_pkg::ctl_t         q_ctl,
  input  wire logic [POS_WIDTH-1:0]   q_prior,
  input  wire logic [tpss_pkg::XW-1:0] q_x,
  output logic                        q_pop,
  input  wire tpss_pkg::coef_t        coef,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [POS_WIDTH-1:0]        out_next,
  output logic                        out_err
);

  localparam int SW = 35;
  localparam int NW = ((POS_WIDTH > SW) ? POS_WIDTH : SW) + 2;
  localparam int NS = 32;
  localparam logic signed [NW-1:0] POS_HI =
    $signed({{(NW-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}});
  localparam logic signed [NW-1:0] POS_LO =
    $signed({{(NW-POS_WIDTH+1){1'b1}}, {(POS_WIDTH-1){1'b0}}});

  logic en;

  logic                  a_v;
  tpss_pkg::ctl_t        a_ctl;
  logic [POS_WIDTH-1:0]  a_prior;
  logic [55:0]           a_x;

  logic                  b_v;
  tpss_pkg::ctl_t        b_ctl;
  logic [POS_WIDTH-1:0]  b_prior;
  logic [46:0]           b_pp [0:3];

  logic                  c_v;
  tpss_pkg::ctl_t        c_ctl;
  logic [POS_WIDTH-1:0]  c_prior;
  logic [63:0]           c_prod;

  logic                  d_v;
  tpss_pkg::ctl_t        d_ctl;
  logic [POS_WIDTH-1:0]  d_prior;
  logic [63:0]           d_rad;

  logic [NS:1]           sq_v;
  logic [63:0]           sq_x     [1:NS];
  logic [63:0]           sq_r     [1:NS];
  tpss_pkg::ctl_t        sq_ctl   [1:NS];
  logic [POS_WIDTH-1:0]  sq_prior [1:NS];

  logic                  m1_v;
  tpss_pkg::ctl_t        m1_ctl;
  logic [POS_WIDTH-1:0]  m1_prior;
  logic [31:0]           m1_speed;
  logic [63:0]           m1_frac;

  logic                  m2_v;
  tpss_pkg::ctl_t        m2_ctl;
  logic [POS_WIDTH-1:0]  m2_prior;
  logic [SW-1:0]         m2_step;

  logic [31:0]           speed;
  logic signed [NW-1:0]  prior_ext;
  logic signed [NW-1:0]  step_ext;
  logic signed [NW-1:0]  sum;
  logic [POS_WIDTH-1:0]  sat;

  // The whole back end advances together whenever the output register can take a result.
  assign en    = !out_valid || out_ready;
  assign q_pop = en && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      c_v       <= 1'b0;
      d_v       <= 1'b0;
      sq_v      <= '0;
      m1_v      <= 1'b0;
      m2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_v       <= q_valid;
      b_v       <= a_v;
      c_v       <= b_v;
      d_v       <= c_v;
      sq_v      <= {sq_v[NS-1:1], d_v};
      m1_v      <= sq_v[NS];
      m2_v      <= m1_v;
      out_valid <= m2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ctl   <= q_ctl;
      a_prior <= q_prior;
      a_x     <= 56'(q_x);

      b_ctl   <= a_ctl;
      b_prior <= a_prior;
      for (int k = 0; k < 4; k++) begin
        b_pp[k] <= 47'(coef.two_acc) * 47'(a_x[14*k +: 14]);
      end

      c_ctl   <= b_ctl;
      c_prior <= b_prior;
      c_prod  <= 64'(b_pp[0]) + (64'(b_pp[1]) << 14) + (64'(b_pp[2]) << 28)
               + (64'(b_pp[3]) << 42);

      d_ctl   <= c_ctl;
      d_prior <= c_prior;
      if (c_ctl.kind == tpss_pkg::KIND_ACCEL) begin
        d_rad <= c_prod;
      end else if (c_ctl.kind == tpss_pkg::KIND_DECEL) begin
        d_rad <= (c_prod >= coef.vsq) ? 64'd0 : (coef.vsq - c_prod);
      end else begin
        d_rad <= 64'd0;
      end
    end
  end

  // One bit of the integer square root per stage.
  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
    logic [63:0]          src_x;
    logic [63:0]          src_r;
    tpss_pkg::ctl_t       src_ctl;
    logic [POS_WIDTH-1:0] src_prior;
    logic [63:0]          trial;

    if (k == 0) begin : g_first
      assign src_x     = d_rad;
      assign src_r     = 64'd0;
      assign src_ctl   = d_ctl;
      assign src_prior = d_prior;
    end else begin : g_next
      assign src_x     = sq_x[k];
      assign src_r     = sq_r[k];
      assign src_ctl   = sq_ctl[k];
      assign src_prior = sq_prior[k];
    end

    assign trial = src_r + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (src_x >= trial) begin
          sq_x[k+1] <= src_x - trial;
          sq_r[k+1] <= (src_r >> 1) + BIT;
        end else begin
          sq_x[k+1] <= src_x;
          sq_r[k+1] <= src_r >> 1;
        end
        sq_ctl[k+1]   <= src_ctl;
        sq_prior[k+1] <= src_prior;
      end
    end
  end

  assign speed = (sq_ctl[NS].kind == tpss_pkg::KIND_CRUISE) ? coef.vmax : sq_r[NS][31:0];

  assign prior_ext = $signed({{(NW-POS_WIDTH){m2_prior[POS_WIDTH-1]}}, m2_prior});
  assign step_ext  = $signed({{(NW-SW){1'b0}}, m2_step});
  assign sum       = m2_ctl.neg ? (prior_ext - step_ext) : (prior_ext + step_ext);

  always_comb begin
    if (sum > POS_HI) begin
      sat = POS_HI[POS_WIDTH-1:0];
    end else if (sum < POS_LO) begin
      sat = POS_LO[POS_WIDTH-1:0];
    end else begin
      sat = sum[POS_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_ctl   <= sq_ctl[NS];
      m1_prior <= sq_prior[NS];
      m1_speed <= speed;
      m1_frac  <= 64'(speed) * 64'(coef.t_lo);

      m2_ctl   <= m1_ctl;
      m2_prior <= m1_prior;
      m2_step  <= SW'(34'(m1_speed) * 34'(coef.t_hi)) + SW'(m1_frac[63:32]);

      out_err  <= m2_ctl.err;
      out_next <= m2_ctl.err ? m2_prior : sat;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/trapezoid_profile_setpoint_step.sv
// Top level of the trapezoid profile setpoint step block with its register port.
`default_nettype none
// Computes the next setpoint of a trapezoidal velocity profile for one joint per stream
// transfer. One item is taken every cycle while the queue is not full and the
// coefficients are not being derived; each item passes the front, queue and product
// stages and the 32-stage square root pipeline. After reset and after every register
// write the block derives its coefficients in one bit-serial divider (up to two 64-step
// divisions) and a reciprocal multiply, and holds s_axis_tready low meanwhile; register
// writes are taken at any time.
module trapezoid_profile_setpoint_step #(
  parameter int POS_WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // prior_setpoint, goal_position
  input  wire logic [((2*POS_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // next_setpoint
  output logic [((POS_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
  // rate_error
  output logic                             m_axis_tuser,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [4:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int OW = ((POS_WIDTH+7)/8)*8;
  localparam int QW = $bits(tpss_pkg::ctl_t) + POS_WIDTH + tpss_pkg::XW;

  logic [31:0] accel_limit;
  logic [31:0] speed_limit;
  logic [15:0] derating;
  logic [15:0] loop_rate_hz;
  logic [19:0] response_delay_us;

  logic            wr_en;
  logic [2:0]      reg_idx;
  tpss_pkg::coef_t coef;
  logic            busy;

  logic                    push;
  tpss_pkg::ctl_t          push_ctl;
  logic [POS_WIDTH-1:0]    push_prior;
  logic [tpss_pkg::XW-1:0] push_x;
  logic                    q_full;
  logic                    q_valid;
  logic                    q_pop;
  logic [QW-1:0]           q_dout;
  tpss_pkg::ctl_t          q_ctl;
  logic [POS_WIDTH-1:0]    q_prior;
  logic [tpss_pkg::XW-1:0] q_x;
  logic [POS_WIDTH-1:0]    out_next;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_limit       <= 32'd65536;
      speed_limit       <= 32'd65536;
      derating          <= 16'd32768;
      loop_rate_hz      <= 16'd1000;
      response_delay_us <= 20'd25000;
    end else if (wr_en) begin
      unique case (reg_idx)
        tpss_pkg::REG_ACCEL_LIMIT: accel_limit       <= pwdata;
        tpss_pkg::REG_SPEED_LIMIT: speed_limit       <= pwdata;
        tpss_pkg::REG_DERATING:    derating          <= pwdata[15:0];
        tpss_pkg::REG_LOOP_RATE:   loop_rate_hz      <= pwdata[15:0];
        tpss_pkg::REG_RESP_DELAY:  response_delay_us <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tpss_pkg::REG_ACCEL_LIMIT: prdata = accel_limit;
      tpss_pkg::REG_SPEED_LIMIT: prdata = speed_limit;
      tpss_pkg::REG_DERATING:    prdata = 32'(derating);
      tpss_pkg::REG_LOOP_RATE:   prdata = 32'(loop_rate_hz);
      tpss_pkg::REG_RESP_DELAY:  prdata = 32'(response_delay_us);
      default:                   prdata = 32'd0;
    endcase
  end

  tpss_coef u_coef (
    .clk               (clk),
    .rst               (rst),
    .start             (wr_en),
    .accel_limit       (accel_limit),
    .speed_limit       (speed_limit),
    .derating          (derating),
    .loop_rate_hz      (loop_rate_hz),
    .response_delay_us (response_delay_us),
    .coef              (coef),
    .busy              (busy)
  );

  tpss_front #(.POS_WIDTH(POS_WIDTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_prior   (s_axis_tdata[POS_WIDTH-1:0]),
    .in_goal    (s_axis_tdata[2*POS_WIDTH-1:POS_WIDTH]),
    .coef       (coef),
    .busy       (busy),
    .q_full     (q_full),
    .push       (push),
    .push_ctl   (push_ctl),
    .push_prior (push_prior),
    .push_x     (push_x)
  );

  tpss_queue #(.WIDTH(QW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   ({push_ctl, push_prior, push_x}),
    .pop   (q_pop),
    .dout  (q_dout),
    .valid (q_valid),
    .full  (q_full)
  );

  assign q_ctl   = q_dout[QW-1 -: $bits(tpss_pkg::ctl_t)];
  assign q_prior = q_dout[tpss_pkg::XW +: POS_WIDTH];
  assign q_x     = q_dout[tpss_pkg::XW-1:0];

  tpss_back #(.POS_WIDTH(POS_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ctl     (q_ctl),
    .q_prior   (q_prior),
    .q_x       (q_x),
    .q_pop     (q_pop),
    .coef      (coef),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_next  (out_next),
    .out_err   (m_axis_tuser)
  );

  assign m_axis_tdata = OW'(out_next);

endmodule
`default_nettype wire
